FILE: hw/rtl/rmts_pkg.sv
`default_nettype none

package rmts_pkg;

   // register map, word index = paddr / 4
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [2:0] REG_TASK_COUNT   = 3'd0;
   localparam logic [2:0] REG_TASK0_TIMING = 3'd1;
   localparam logic [2:0] REG_TASK1_TIMING = 3'd2;
   localparam logic [2:0] REG_TASK2_TIMING = 3'd3;
   localparam logic [2:0] REG_TASK3_TIMING = 3'd4;

   // timing registers that exist, one per schedulable task
   localparam int TIMING_REGS = 4;
   localparam int FIELD_BITS  = 16;
   localparam int INDEX_BITS  = 2;
   localparam int COUNT_BITS  = 3;

   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 24;

   // result item, running_task in the lowest bits
   typedef struct packed {
      logic [FIELD_BITS-1:0] time_now;
      logic                  halted;
      logic [INDEX_BITS-1:0] missed_task;
      logic                  deadline_miss;
      logic                  idle;
      logic [INDEX_BITS-1:0] running_task;
   } rsp_type;

   localparam int RSP_BITS = $bits(rsp_type);

endpackage

`default_nettype wire

FILE: hw/rtl/rate_monotonic_tick_scheduler_unit.sv
`default_nettype none
// a result is registered and valid in the cycle after its input item is accepted
// throughput: one item per cycle while results drain; the whole tick (release,
// priority pick, countdown update) is one pass of logic into the result register
// reset: synchronous, active high; clears task state, time and the halt flag,
// and loads task_count = 1 and every timing register with period 1, execution 0

module rate_monotonic_tick_scheduler_unit #(
   parameter int MAX_TASKS = 4,
   parameter int TIME_BITS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // input item: [0] advance, rest zero
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [rmts_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // result item: [1:0] running_task, [2] idle, [3] deadline_miss,
   // [5:4] missed_task, [6] halted, [22:7] time_now, [23] zero
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [rmts_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // register port
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [rmts_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire  [rmts_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [rmts_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   import rmts_pkg::*;

   // only tasks that own a timing register can ever be scheduled
   localparam int NUM_TASKS = (MAX_TASKS < TIMING_REGS) ? MAX_TASKS : TIMING_REGS;

   // configuration
   logic [COUNT_BITS-1:0]    task_count_ff;
   logic [CSR_DATA_BITS-1:0] timing_ff [TIMING_REGS];
   logic [2:0]               csr_index;
   logic                     csr_write;

   // scheduler state
   logic [FIELD_BITS-1:0] countdown_ff [NUM_TASKS];
   logic [FIELD_BITS-1:0] countdown_in [NUM_TASKS];
   logic [FIELD_BITS-1:0] work_ff      [NUM_TASKS];
   logic [FIELD_BITS-1:0] work_in      [NUM_TASKS];
   logic [TIME_BITS-1:0]  time_ff;
   logic [TIME_BITS-1:0]  time_in;
   logic                  stopped_ff;
   logic                  stopped_in;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic req_accept;
   logic tick;

   // ---------------------------------------------------------------------
   // register port: writes land in the access phase, reads are immediate
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= COUNT_BITS'(1);
         for (int k = 0; k < TIMING_REGS; k++) begin
            timing_ff[k] <= 32'h0001_0000;
         end
      end else if (csr_write) begin
         case (csr_index)
            REG_TASK_COUNT:   task_count_ff <= csr_pwdata[COUNT_BITS-1:0];
            REG_TASK0_TIMING: timing_ff[0]  <= csr_pwdata;
            REG_TASK1_TIMING: timing_ff[1]  <= csr_pwdata;
            REG_TASK2_TIMING: timing_ff[2]  <= csr_pwdata;
            REG_TASK3_TIMING: timing_ff[3]  <= csr_pwdata;
            default: ;  // unmapped addresses are ignored
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TASK_COUNT:   csr_prdata = {{(CSR_DATA_BITS-COUNT_BITS){1'b0}}, task_count_ff};
         REG_TASK0_TIMING: csr_prdata = timing_ff[0];
         REG_TASK1_TIMING: csr_prdata = timing_ff[1];
         REG_TASK2_TIMING: csr_prdata = timing_ff[2];
         REG_TASK3_TIMING: csr_prdata = timing_ff[3];
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // handshake: take a new item whenever the result register is free or
   // is being drained in the same cycle
   // ---------------------------------------------------------------------
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   // an item with advance clear is consumed without a result
   assign tick       = req_accept & req_tdata[0];

   // ---------------------------------------------------------------------
   // one tick: release, miss check, rate-monotonic pick
   // ---------------------------------------------------------------------
   always_comb begin
      logic                  active    [NUM_TASKS];
      logic                  release_i [NUM_TASKS];
      logic [FIELD_BITS-1:0] period    [NUM_TASKS];
      logic [FIELD_BITS-1:0] work_rel  [NUM_TASKS];
      logic                  miss;
      logic [INDEX_BITS-1:0] missed;
      logic                  found;
      logic [INDEX_BITS-1:0] best;
      logic [FIELD_BITS-1:0] best_period;
      logic [31:0]           time_wide;

      miss        = 1'b0;
      missed      = '0;
      found       = 1'b0;
      best        = '0;
      best_period = '0;
      time_wide   = 32'(time_ff);

      for (int i = 0; i < NUM_TASKS; i++) begin
         active[i]    = int'(task_count_ff) > i;
         // a period of zero behaves as one
         period[i]    = (timing_ff[i][31:16] == '0) ? FIELD_BITS'(1) : timing_ff[i][31:16];
         release_i[i] = active[i] & (countdown_ff[i] == '0);
         work_rel[i]  = release_i[i] ? timing_ff[i][15:0] : work_ff[i];
         if (release_i[i]) begin
            countdown_in[i] = period[i] - FIELD_BITS'(1);
         end else if (active[i]) begin
            countdown_in[i] = countdown_ff[i] - FIELD_BITS'(1);
         end else begin
            countdown_in[i] = countdown_ff[i];
         end
      end

      // lowest index wins, so walk down
      for (int i = NUM_TASKS - 1; i >= 0; i--) begin
         if (release_i[i] && work_ff[i] != '0) begin
            miss   = 1'b1;
            missed = INDEX_BITS'(i);
         end
      end

      // smallest period among ready tasks, ties keep the lower index
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (active[i] && work_rel[i] != '0 && (!found || period[i] < best_period)) begin
            found       = 1'b1;
            best        = INDEX_BITS'(i);
            best_period = period[i];
         end
      end

      for (int i = 0; i < NUM_TASKS; i++) begin
         work_in[i] = work_rel[i];
         if (found && !miss && best == INDEX_BITS'(i)) begin
            work_in[i] = work_rel[i] - FIELD_BITS'(1);
         end
      end

      time_in    = time_ff + TIME_BITS'(1);
      stopped_in = miss;

      // default result, also what a halted block reports
      rsp_in.running_task  = '0;
      rsp_in.idle          = 1'b1;
      rsp_in.deadline_miss = 1'b0;
      rsp_in.missed_task   = '0;
      rsp_in.halted        = 1'b1;
      rsp_in.time_now      = time_wide[FIELD_BITS-1:0];

      if (!stopped_ff) begin
         if (miss) begin
            rsp_in.deadline_miss = 1'b1;
            rsp_in.missed_task   = missed;
         end else begin
            rsp_in.halted = 1'b0;
            if (found) begin
               rsp_in.running_task = best;
               rsp_in.idle         = 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // state update, only on a tick while not halted
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            countdown_ff[i] <= '0;
            work_ff[i]      <= '0;
         end
         time_ff    <= '0;
         stopped_ff <= 1'b0;
      end else if (tick && !stopped_ff) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            countdown_ff[i] <= countdown_in[i];
            work_ff[i]      <= work_in[i];
         end
         time_ff    <= time_in;
         stopped_ff <= stopped_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= req_tdata[0];
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-RSP_BITS){1'b0}}, rsp_ff};

`ifndef NO_ASSERTIONS
   // once halted, only reset brings the scheduler back
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("halt flag cleared without reset");

   // a halted scheduler does not advance time
   a_halt_freezes_time: assert property (@(posedge clock) disable iff (reset)
      (stopped_ff && tick) |=> $stable(time_ff))
      else $error("time advanced while halted");

   // a reported miss always comes with idle and halted
   a_miss_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.deadline_miss) |-> (rsp_ff.idle && rsp_ff.halted))
      else $error("miss reported without idle and halted");

   // a running task is never reported from a halted block
   a_run_not_halted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.idle) |-> (!rsp_ff.halted && !rsp_ff.deadline_miss))
      else $error("task reported as running while halted");

   // a tick that finds a miss sets the halt flag
   a_miss_halts: assert property (@(posedge clock) disable iff (reset)
      (tick && !stopped_ff && rsp_in.deadline_miss) |=> stopped_ff)
      else $error("miss did not halt the scheduler");
`endif

endmodule

`default_nettype wire
